@@ rtl/core/gb5_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gb5_pkg;

	localparam int KERNEL_SIZE = 5;
	localparam int HALF        = KERNEL_SIZE / 2;
	localparam int LINES       = KERNEL_SIZE - 1;
	localparam int MAX_WIDTH   = 2048;
	localparam int ADDR_W      = $clog2(MAX_WIDTH);
	localparam int CHANNELS    = 3;
	localparam int CH_W        = 8;
	localparam int PIX_W       = CHANNELS * CH_W;
	localparam int WIDTH_W     = 12;
	localparam int COL_W       = 11;
	localparam int ROW_W       = 12;
	localparam int ROW_MAX     = 4095;
	localparam int WEIGHT_W    = 16;
	localparam int NUM_GROUPS  = 6;
	localparam int GSUM_W      = 11;
	localparam int PROD_W      = GSUM_W + WEIGHT_W;
	localparam int ACC_W       = 30;
	localparam int FRAC_W      = 16;
	localparam int CFG_IDX_W   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH   = 3'd0,
		CFG_W_CENTER      = 3'd1,
		CFG_W_AXIS_ONE    = 3'd2,
		CFG_W_AXIS_TWO    = 3'd3,
		CFG_W_DIAG_ONE    = 3'd4,
		CFG_W_DIAG_ONE_TWO = 3'd5,
		CFG_W_DIAG_TWO    = 3'd6
	} cfg_reg_t;

	// Weight group of a window tap, from its row and column distance to the center.
	function automatic logic [2:0] weight_group(input int r, input int c);
		int dr;
		int dc;
		dr = (r > HALF) ? r - HALF : HALF - r;
		dc = (c > HALF) ? c - HALF : HALF - c;
		if (dr == 0 && dc == 0) begin
			return 3'd0;
		end else if ((dr == 0 && dc == 1) || (dr == 1 && dc == 0)) begin
			return 3'd1;
		end else if ((dr == 0 && dc == 2) || (dr == 2 && dc == 0)) begin
			return 3'd2;
		end else if (dr == 1 && dc == 1) begin
			return 3'd3;
		end else if ((dr == 1 && dc == 2) || (dr == 2 && dc == 1)) begin
			return 3'd4;
		end else begin
			return 3'd5;
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/gaussian_blur_5x5_rgb.sv @@
// 5x5 Gaussian blur over a stream of RGB pixels in raster order.
// Input items arrive on s_axis: tdata carries red, green and blue, and
// tuser marks the first pixel of a frame. Only pixels at row 4 or later and
// column 4 or later produce a result; the others fill the line store and the
// window and produce nothing. Results leave on m_axis with the blurred
// channels and the row and column of the window's top left corner.
// Registers are written on the cfg channel, which is always ready; writes
// are meant to happen while the block is idle.
// One item is accepted per cycle unless the pipeline stalls. The line store
// is a single-port-write, single-port-read memory holding four lines per
// column, and each item does one read and one write-back of its column
// entry, so the rate is one item per clock while nothing stalls. A result
// reaches m_axis through the memory read, the window update with tap
// grouping, the multiply, the sum and the saturating output register.
// When the receiver stalls, the output register holds the result and the
// pipeline behind it keeps filling; s_axis_tready falls only once every
// stage that carries a result is occupied.
// Reset clears the window, the counters and the pipeline, and loads the
// default width of 640 and the default weights. The line store is not
// cleared and needs no startup pass.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_5x5_rgb import gb5_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [PIX_W-1:0]     s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
	input  wire logic                 s_axis_tuser,  // frame_start
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [47:0]               m_axis_tdata,  // out_red, out_green, out_blue,
	                                                 // out_row, out_col, zero pad
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WEIGHT_W-1:0]  cfg_data
);

	logic [WIDTH_W-1:0]  img_w_q;
	logic [WEIGHT_W-1:0] wt_q [NUM_GROUPS];

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [WIDTH_W-1:0] width_c;
	logic [COL_W-1:0]   col_start;
	logic [ROW_W-1:0]   row_start;
	logic [COL_W-1:0]   col_cur;
	logic [WIDTH_W-1:0] col_inc;
	logic               wrap;
	logic               produce;
	logic [ADDR_W-1:0]  rd_addr;
	logic               accept;

	logic [LINES*PIX_W-1:0] ls_mem [MAX_WIDTH];
	logic [LINES*PIX_W-1:0] ls_rd_s1;
	logic [LINES*PIX_W-1:0] line_old;
	logic [LINES*PIX_W-1:0] ls_wdata;
	logic                   ls_we;

	logic                   v1_q;
	logic [PIX_W-1:0]       pix_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic                   res_s1;
	logic [ROW_W-1:0]       row_s1;
	logic [COL_W-1:0]       col_s1;
	logic                   byp_s1;
	logic [LINES*PIX_W-1:0] byp_data_s1;
	logic                   leave1;

	logic [PIX_W-1:0] col_vec [KERNEL_SIZE];
	logic [PIX_W-1:0] win_q [KERNEL_SIZE][KERNEL_SIZE];
	logic [PIX_W-1:0] win_n [KERNEL_SIZE][KERNEL_SIZE];
	logic [GSUM_W-1:0] gsum [CHANNELS][NUM_GROUPS];

	logic              v2_q;
	logic              adv2;
	logic [GSUM_W-1:0] gs_s2 [CHANNELS][NUM_GROUPS];
	logic [ROW_W-1:0]  row_s2;
	logic [COL_W-1:0]  col_s2;

	logic              v3_q;
	logic              adv3;
	logic [PROD_W-1:0] pr_s3 [CHANNELS][NUM_GROUPS];
	logic [ROW_W-1:0]  row_s3;
	logic [COL_W-1:0]  col_s3;

	logic             v4_q;
	logic             adv4;
	logic [ACC_W-1:0] sum_s4 [CHANNELS];
	logic [ACC_W-1:0] sum_c [CHANNELS];
	logic [ROW_W-1:0] row_s4;
	logic [COL_W-1:0] col_s4;

	logic             ov_q;
	logic             ov_en;
	logic [CH_W-1:0]  ochan_q [CHANNELS];
	logic [ROW_W-1:0] orow_q;
	logic [COL_W-1:0] ocol_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= WIDTH_W'(640);
			wt_q[0] <= WEIGHT_W'(10623);
			wt_q[1] <= WEIGHT_W'(6443);
			wt_q[2] <= WEIGHT_W'(1437);
			wt_q[3] <= WEIGHT_W'(3908);
			wt_q[4] <= WEIGHT_W'(872);
			wt_q[5] <= WEIGHT_W'(195);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:    img_w_q <= cfg_data[WIDTH_W-1:0];
				CFG_W_CENTER:       wt_q[0] <= cfg_data;
				CFG_W_AXIS_ONE:     wt_q[1] <= cfg_data;
				CFG_W_AXIS_TWO:     wt_q[2] <= cfg_data;
				CFG_W_DIAG_ONE:     wt_q[3] <= cfg_data;
				CFG_W_DIAG_ONE_TWO: wt_q[4] <= cfg_data;
				CFG_W_DIAG_TWO:     wt_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Position tracking for the item on the input side.
	always_comb begin
		if (img_w_q > WIDTH_W'(MAX_WIDTH)) begin
			width_c = WIDTH_W'(MAX_WIDTH);
		end else if (img_w_q == '0) begin
			width_c = WIDTH_W'(1);
		end else begin
			width_c = img_w_q;
		end
		col_start = s_axis_tuser ? '0 : col_q;
		row_start = s_axis_tuser ? '0 : row_q;
		col_cur   = ({1'b0, col_start} >= width_c) ? '0 : col_start;
		col_inc   = {1'b0, col_cur} + WIDTH_W'(1);
		wrap      = col_inc >= width_c;
		produce   = (row_start >= ROW_W'(LINES)) && (col_cur >= COL_W'(LINES));
		rd_addr   = col_cur[ADDR_W-1:0];
	end

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !v1_q || !res_s1 || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= wrap ? '0 : col_inc[COL_W-1:0];
			if (wrap && row_start != ROW_W'(ROW_MAX)) begin
				row_q <= row_start + ROW_W'(1);
			end else begin
				row_q <= row_start;
			end
		end
	end

	// Line store: four lines per column, oldest line in the lowest bits.
	always_ff @(posedge clk) begin
		if (ls_we) begin
			ls_mem[addr_s1] <= ls_wdata;
		end
		if (accept) begin
			ls_rd_s1 <= ls_mem[rd_addr];
		end
	end

	// Stage 1: column entry read back, window shift, line store write-back.
	assign leave1   = v1_q && (!res_s1 || adv2);
	assign ls_we    = leave1;
	assign line_old = byp_s1 ? byp_data_s1 : ls_rd_s1;
	assign ls_wdata = {pix_s1, line_old[LINES*PIX_W-1:PIX_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (accept) begin
			v1_q <= 1'b1;
		end else if (leave1) begin
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= s_axis_tdata;
			addr_s1     <= rd_addr;
			res_s1      <= produce;
			row_s1      <= row_start - ROW_W'(LINES);
			col_s1      <= col_cur - COL_W'(LINES);
			byp_s1      <= leave1 && (addr_s1 == rd_addr);
			byp_data_s1 <= ls_wdata;
		end
	end

	always_comb begin
		for (int k = 0; k < LINES; k++) begin
			col_vec[k] = line_old[k*PIX_W +: PIX_W];
		end
		col_vec[LINES] = pix_s1;
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
				win_n[r][c] = win_q[r][c+1];
			end
			win_n[r][KERNEL_SIZE-1] = col_vec[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				for (int c = 0; c < KERNEL_SIZE; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (leave1) begin
			win_q <= win_n;
		end
	end

	// Taps that share a weight are added before the multiply.
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				gsum[ch][g] = '0;
			end
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				for (int c = 0; c < KERNEL_SIZE; c++) begin
					gsum[ch][weight_group(r, c)] = gsum[ch][weight_group(r, c)]
						+ GSUM_W'(win_n[r][c][ch*CH_W +: CH_W]);
				end
			end
		end
	end

	// Stage 2: grouped tap sums.
	assign adv2 = !v2_q || adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (adv2) begin
			v2_q <= leave1 && res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			gs_s2  <= gsum;
			row_s2 <= row_s1;
			col_s2 <= col_s1;
		end
	end

	// Stage 3: one product per channel and weight group.
	assign adv3 = !v3_q || adv4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
		end else if (adv3) begin
			v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				for (int g = 0; g < NUM_GROUPS; g++) begin
					pr_s3[ch][g] <= PROD_W'(gs_s2[ch][g] * wt_q[g]);
				end
			end
			row_s3 <= row_s2;
			col_s3 <= col_s2;
		end
	end

	// Stage 4: full sum per channel.
	assign adv4 = !v4_q || ov_en;

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			sum_c[ch] = '0;
			for (int g = 0; g < NUM_GROUPS; g++) begin
				sum_c[ch] = sum_c[ch] + ACC_W'(pr_s3[ch][g]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_q <= 1'b0;
		end else if (adv4) begin
			v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			sum_s4 <= sum_c;
			row_s4 <= row_s3;
			col_s4 <= col_s3;
		end
	end

	// Output register: drop the fraction and saturate.
	assign ov_en = !ov_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ov_en) begin
			ov_q <= v4_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ov_en) begin
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (sum_s4[ch][ACC_W-1:FRAC_W+CH_W] != '0) begin
					ochan_q[ch] <= '1;
				end else begin
					ochan_q[ch] <= sum_s4[ch][FRAC_W +: CH_W];
				end
			end
			orow_q <= row_s4;
			ocol_q <= col_s4;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {1'b0, ocol_q, orow_q, ochan_q[2], ochan_q[1], ochan_q[0]};

	// A stalled stage-one item must keep its column and pixel until it writes back.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && !leave1) |=> (v1_q && $stable(addr_s1) && $stable(pix_s1)))
		else $error("stage one item changed while stalled");

	// A result waiting in stage four is never dropped; its first channel sum and its row stay stable.
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_q && !adv4) |=> (v4_q && $stable(sum_s4[0]) && $stable(row_s4)))
		else $error("stage four result lost under stall");

	// A result only reaches the output from a valid stage four.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(v4_q))
		else $error("output item without a source");

endmodule

`default_nettype wire

@@ verif/tb_gaussian_blur_5x5_rgb.sv @@
`timescale 1ns / 1ps

module tb_gaussian_blur_5x5_rgb;
	import gb5_pkg::*;

	localparam int RANDOM_ITEMS = 900;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  red;
	} blur_px_t;

	typedef struct packed {
		bit                  is_reg;
		cfg_reg_t            idx;
		bit [WEIGHT_W-1:0]   val;
		bit [PIX_W-1:0]      pix;
		bit                  fs;
		bit                  typed;
		blur_px_t            want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [PIX_W-1:0]     s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [47:0]          m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WEIGHT_W-1:0]  cfg_data = '0;

	// Predictor state: line stores, window, position and register copies.
	bit [PIX_W-1:0]    line_mem [LINES][MAX_WIDTH];
	bit [PIX_W-1:0]    win [KERNEL_SIZE][KERNEL_SIZE];
	int unsigned       col_pos = 0;
	int unsigned       row_pos = 0;
	bit [WIDTH_W-1:0]  cfg_width = WIDTH_W'(640);
	bit [WEIGHT_W-1:0] wt_default [NUM_GROUPS] =
		'{16'd10623, 16'd6443, 16'd1437, 16'd3908, 16'd872, 16'd195};
	bit [WEIGHT_W-1:0] wt [NUM_GROUPS];
	bit [WEIGHT_W-1:0] next_regs [NUM_GROUPS + 1];

	blur_px_t    pending_blurs [$];
	stim_row_t   plan [$];
	blur_px_t    got;
	blur_px_t    want;
	bit          steady = 1'b0;
	int          rx_hold = 0;
	int unsigned fail_count = 0;
	int unsigned results_checked = 0;
	int unsigned pixels_sent = 0;
	int unsigned settings_applied = 0;

	gaussian_blur_5x5_rgb u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_pause();
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return 0;
		end else if (r < 96) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 24);
	endfunction

	function automatic bit [PIX_W-1:0] random_pixel();
		bit [PIX_W-1:0] pix;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			case ($urandom_range(0, 7))
				0: pix[ch*CH_W +: CH_W] = '0;
				1: pix[ch*CH_W +: CH_W] = '1;
				default: pix[ch*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
			endcase
		end
		return pix;
	endfunction

	function automatic bit [CH_W-1:0] blur_channel(input int ch);
		longint unsigned acc;
		int dr;
		int dc;
		int lo;
		int hi;
		acc = 0;
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			for (int c = 0; c < KERNEL_SIZE; c++) begin
				dr = (r > HALF) ? r - HALF : HALF - r;
				dc = (c > HALF) ? c - HALF : HALF - c;
				lo = (dr < dc) ? dr : dc;
				hi = (dr < dc) ? dc : dr;
				// The weight of a tap is picked by its smaller and larger distance to the center.
				acc += 64'(win[r][c][ch*CH_W +: CH_W])
					* 64'(wt[(lo == 0) ? hi : lo + hi + 1]);
			end
		end
		acc = acc >> FRAC_W;
		return (acc > 255) ? 8'd255 : acc[CH_W-1:0];
	endfunction

	function automatic stim_row_t reg_row(input cfg_reg_t idx, input bit [WEIGHT_W-1:0] val);
		stim_row_t entry;
		entry = '0;
		entry.is_reg = 1'b1;
		entry.idx = idx;
		entry.val = val;
		return entry;
	endfunction

	function automatic stim_row_t pixel_row(input bit [PIX_W-1:0] pix, input bit fs);
		stim_row_t entry;
		entry = '0;
		entry.pix = pix;
		entry.fs = fs;
		return entry;
	endfunction

	task automatic send_pixel(input bit [PIX_W-1:0] pix, input bit fs, input bit typed,
			input blur_px_t typed_blur);
		int gap;
		int unsigned w;
		bit [PIX_W-1:0] stack [KERNEL_SIZE];
		blur_px_t res;
		gap = pick_pause();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		s_axis_tuser <= fs;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pixels_sent++;

		w = cfg_width;
		if (w > MAX_WIDTH) begin
			w = MAX_WIDTH;
		end
		if (w == 0) begin
			w = 1;
		end
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
		end
		for (int k = 0; k < LINES; k++) begin
			stack[k] = line_mem[k][col_pos];
		end
		stack[LINES] = pix;
		for (int k = 0; k < LINES; k++) begin
			line_mem[k][col_pos] = stack[k + 1];
		end
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
				win[r][c] = win[r][c + 1];
			end
			win[r][KERNEL_SIZE - 1] = stack[r];
		end
		if (row_pos >= LINES && col_pos >= LINES) begin
			res.red = blur_channel(0);
			res.green = blur_channel(1);
			res.blue = blur_channel(2);
			res.row = ROW_W'(row_pos - LINES);
			res.col = COL_W'(col_pos - LINES);
			pending_blurs.push_back(typed ? typed_blur : res);
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			if (row_pos < ROW_MAX) begin
				row_pos++;
			end
		end
	endtask

	// Items that produce no result may still be in flight when the queue drains.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_blurs.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input bit [WEIGHT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_IMAGE_WIDTH) begin
			cfg_width = val[WIDTH_W-1:0];
		end else begin
			wt[int'(idx) - int'(CFG_W_CENTER)] = val;
		end
	endtask

	task automatic apply_setting();
		wait_idle();
		for (int i = 0; i <= int'(CFG_W_DIAG_TWO); i++) begin
			write_reg(cfg_reg_t'(i), next_regs[i]);
		end
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			got = m_axis_tdata[46:0];
			if (pending_blurs.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected result: r=%0d g=%0d b=%0d row=%0d col=%0d",
						got.red, got.green, got.blue, got.row, got.col);
				end
			end else begin
				want = pending_blurs.pop_front();
				results_checked++;
				if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue || got.row !== want.row
						|| got.col !== want.col || m_axis_tdata[47] !== 1'b0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("result %0d wrong: expected r=%0d g=%0d b=%0d row=%0d col=%0d",
							results_checked, want.red, want.green, want.blue, want.row,
							want.col);
						$display("  got r=%0d g=%0d b=%0d row=%0d col=%0d pad=%b",
							got.red, got.green, got.blue, got.row, got.col,
							m_axis_tdata[47]);
					end
				end
			end
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			rx_hold = pick_pause();
			m_axis_tready <= (rx_hold == 0);
		end
	end

	initial begin
		#60_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int w;
		int nw;
		int n;
		int mode;
		int unsigned random_items;
		stim_row_t entry;
		bit [CH_W-1:0] blue;

		random_items = 0;
		foreach (wt[g]) begin
			wt[g] = wt_default[g];
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The smallest frame reaches its first result on its 25th item; the default
		// weights are still in place. Then every weight at its maximum saturates red
		// and blue, while a zero green channel stays zero.
		plan.push_back(reg_row(CFG_IMAGE_WIDTH, 16'd5));
		for (int i = 0; i < 25; i++) begin
			blue = (i == 0) ? 8'h00 : (i == 24) ? 8'hFF : 8'h01 << (i % 8);
			plan.push_back(pixel_row({blue, 8'h00, 8'hFF}, i == 0));
		end
		for (int i = int'(CFG_W_CENTER); i <= int'(CFG_W_DIAG_TWO); i++) begin
			plan.push_back(reg_row(cfg_reg_t'(i), 16'hFFFF));
		end
		for (int i = 0; i < 5; i++) begin
			entry = pixel_row(24'hFF00FF, 1'b0);
			if (i == 4) begin
				entry.typed = 1'b1;
				entry.want.red = 8'd255;
				entry.want.green = 8'd0;
				entry.want.blue = 8'd255;
				entry.want.row = 12'd1;
				entry.want.col = 11'd0;
			end
			plan.push_back(entry);
		end
		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				if (i == 0 || !plan[i - 1].is_reg) begin
					wait_idle();
				end
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				if (cfg_valid) begin
					cfg_valid <= 1'b0;
				end
				send_pixel(plan[i].pix, plan[i].fs, plan[i].typed, plan[i].want);
			end
		end

		while (random_items < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: w = $urandom_range(5, 9);
				7, 8: w = $urandom_range(10, 24);
				default: w = $urandom_range(25, 64);
			endcase
			// Bits above the width field are ignored by the block.
			next_regs[0] = 16'(w) | (16'($urandom_range(0, 15)) << WIDTH_W);
			mode = $urandom_range(0, 5);
			for (int g = 1; g <= NUM_GROUPS; g++) begin
				case (mode)
					0: next_regs[g] = '1;
					1: next_regs[g] = '0;
					2: next_regs[g] = wt_default[g - 1];
					3: next_regs[g] = WEIGHT_W'($urandom_range(0, 65535));
					// Below 2622 the 25 taps sum to less than one, so nothing saturates.
					default: next_regs[g] = WEIGHT_W'($urandom_range(0, 2621));
				endcase
			end
			apply_setting();
			n = $urandom_range(5, 8);
			for (int r = 0; r < n; r++) begin
				for (int c = 0; c < w; c++) begin
					send_pixel(random_pixel(),
						(r == 0 && c == 0) || ($urandom_range(0, 149) == 0), 1'b0, '0);
					random_items++;
				end
			end
			if ($urandom_range(0, 3) == 0 && w > 5) begin
				// Narrow the image in the middle of a row and keep the frame going.
				repeat ($urandom_range(1, w - 1)) begin
					send_pixel(random_pixel(), 1'b0, 1'b0, '0);
					random_items++;
				end
				nw = $urandom_range(5, w - 1);
				next_regs[0] = 16'(nw);
				apply_setting();
				repeat (3 * nw) begin
					send_pixel(random_pixel(), 1'b0, 1'b0, '0);
					random_items++;
				end
			end
		end

		steady = 1'b0;
		for (int t = 0; t < 3; t++) begin
			next_regs[0] = (t == 2) ? 16'd4 : 16'(t);
			apply_setting();
			for (int i = 0; i < 30; i++) begin
				send_pixel(random_pixel(), i == 0, 1'b0, '0);
			end
		end

		next_regs[0] = 16'hFFFF;
		for (int g = 1; g <= NUM_GROUPS; g++) begin
			next_regs[g] = WEIGHT_W'($urandom_range(0, 2621));
		end
		apply_setting();
		for (int i = 0; i < 40; i++) begin
			send_pixel(random_pixel(), i == 0, 1'b0, '0);
		end

		wait_idle();
		$display("Sent %0d pixels under %0d register settings and compared %0d blurred items.",
			pixels_sent, settings_applied, results_checked);
		$display("Widths below five, an oversize width and narrowing mid frame were included.");
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
